@@ hdl/pics_pkg.sv @@
package pics_pkg;

    localparam int GLITCH_LIMIT     = 2500;
    localparam int TICKS_PER_SECOND = 10;
    localparam int LAST_GOOD_RESET  = 1005;
    localparam int SETTLE_TICKS     = (TICKS_PER_SECOND * 500) / 1000;
    localparam int GAP_TICKS        = (TICKS_PER_SECOND * 200) / 1000;

    localparam int SAMPLE_W = 16;
    localparam int PRESS_W  = $clog2(GLITCH_LIMIT + 1) + 1;
    localparam int COUNT_W  = 7;
    localparam int TARGET_W = 14;
    localparam int WAIT_W   = 11;
    localparam int IDLE_W   = $clog2(TICKS_PER_SECOND);
    localparam int READ_W   = 2;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TARGET_W;

    localparam logic [PHASE_W-1:0] PH_IDLE        = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ARMED       = 3'd1;
    localparam logic [PHASE_W-1:0] PH_INFLATE     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SETTLE      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_READOUT     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_PAUSE       = 3'd5;
    localparam logic [PHASE_W-1:0] PH_CYCLE_PAUSE = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPETITION_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_SECONDS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PRESSURE  = 2'd3;

    localparam logic [READ_W-1:0] READOUTS_AFTER_FIRST = 2'd2;

    typedef logic signed [PRESS_W-1:0] press_t;

endpackage

@@ hdl/pics_glitch_filter.sv @@
module pics_glitch_filter (
    input  logic signed [pics_pkg::SAMPLE_W-1:0] sample,
    input  pics_pkg::press_t                     last_good,
    output pics_pkg::press_t                     value
);

    localparam logic signed [pics_pkg::SAMPLE_W-1:0] LIMIT_POS =
        pics_pkg::SAMPLE_W'(pics_pkg::GLITCH_LIMIT);
    localparam logic signed [pics_pkg::SAMPLE_W-1:0] LIMIT_NEG =
        pics_pkg::SAMPLE_W'(-pics_pkg::GLITCH_LIMIT);

    logic glitch;

    // magnitude over the limit means a bad reading
    assign glitch = (sample > LIMIT_POS) || (sample < LIMIT_NEG);
    assign value  = glitch ? last_good : sample[pics_pkg::PRESS_W-1:0];

endmodule

@@ hdl/pneumatic_inflate_cycle_sequencer.sv @@
// the result of an accepted item is registered in the output register
// throughput: one item per cycle; the whole sequencer state updates in one step
// the input stalls only while the output register holds an untaken result
// reset (aresetn low, synchronous): phase idle, counters and configuration registers zero,
// last good pressure 1005, no result pending
module pneumatic_inflate_cycle_sequencer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [pics_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [pics_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [23:0]                        s_axis_tdata,  // pressure_sample, link_up
    input  logic                               s_axis_tuser,  // kind
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // valve_open, report_pressure, busy_res
    output logic                               m_axis_tuser   // report_valid
);

    localparam int SW = pics_pkg::SAMPLE_W;
    localparam int PW = pics_pkg::PRESS_W;
    localparam int CW = pics_pkg::COUNT_W;
    localparam int TW = pics_pkg::TARGET_W;
    localparam int WW = pics_pkg::WAIT_W;
    localparam int IW = pics_pkg::IDLE_W;
    localparam int RW = pics_pkg::READ_W;
    localparam int HW = pics_pkg::PHASE_W;
    localparam int CMPW = SW + 1;

    logic [CW-1:0] cycle_count_reg, repetition_count_reg, pause_seconds_reg;
    logic [TW-1:0] target_pressure_reg;
    logic [HW-1:0] phase_reg, phase_next;
    logic [CW-1:0] cycles_left_reg, cycles_left_next;
    logic [CW-1:0] repeats_left_reg, repeats_left_next;
    logic [WW-1:0] wait_ticks_reg, wait_ticks_next;
    logic [RW-1:0] readouts_left_reg, readouts_left_next;
    logic [IW-1:0] idle_ticks_reg, idle_ticks_next;
    pics_pkg::press_t last_good_reg, last_good_next;

    logic             out_valid_reg;
    logic             valve_reg, report_valid_reg, busy_reg;
    pics_pkg::press_t report_reg;

    logic             accept;
    logic             kind_start, link_up;
    logic [SW-1:0]    sample;
    pics_pkg::press_t filt;
    logic             f_ge_target;
    logic [WW-1:0]    cycle_wait, pause_wait;
    logic             rep_valid;
    logic             fin;

    assign sample     = s_axis_tdata[SW-1:0];
    assign link_up    = s_axis_tdata[SW];
    assign kind_start = s_axis_tuser;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    pics_glitch_filter u_filter (
        .sample    (sample),
        .last_good (last_good_reg),
        .value     (filt)
    );

    assign f_ge_target = CMPW'(filt) >= $signed({{(CMPW-TW){1'b0}}, target_pressure_reg});
    assign cycle_wait  = WW'(pause_seconds_reg * (pics_pkg::TICKS_PER_SECOND * 2));
    assign pause_wait  = WW'(pics_pkg::GAP_TICKS)
                       + WW'(pause_seconds_reg * pics_pkg::TICKS_PER_SECOND);

    always_comb begin
        logic do_scp, do_ce, do_bc, do_br, done;
        logic [CW-1:0] c_dec, r_dec;
        do_scp = 1'b0;
        do_ce  = 1'b0;
        do_bc  = 1'b0;
        do_br  = 1'b0;
        fin    = 1'b0;
        done   = 1'b0;
        c_dec  = '0;
        r_dec  = '0;
        rep_valid          = 1'b0;
        phase_next         = phase_reg;
        cycles_left_next   = cycles_left_reg;
        repeats_left_next  = repeats_left_reg;
        wait_ticks_next    = wait_ticks_reg;
        readouts_left_next = readouts_left_reg;
        idle_ticks_next    = idle_ticks_reg;
        last_good_next     = last_good_reg;

        // shared wait countdown
        if (wait_ticks_reg > WW'(1)) begin
            done = 1'b0;
        end else begin
            done = 1'b1;
        end

        if (kind_start) begin
            if (phase_reg == pics_pkg::PH_IDLE && target_pressure_reg != '0) begin
                phase_next = pics_pkg::PH_ARMED;
            end
        end else begin
            case (phase_reg)
                pics_pkg::PH_IDLE: begin
                    if (!link_up) begin
                        idle_ticks_next = '0;
                    end else if (idle_ticks_reg == '0) begin
                        rep_valid       = 1'b1;
                        last_good_next  = filt;
                        idle_ticks_next = IW'(pics_pkg::TICKS_PER_SECOND - 1);
                    end else begin
                        idle_ticks_next = idle_ticks_reg - IW'(1);
                    end
                end
                pics_pkg::PH_ARMED: begin
                    if (link_up) begin
                        cycles_left_next = cycle_count_reg;
                        if (cycle_count_reg == '0) begin
                            fin = 1'b1;
                        end else begin
                            do_bc = 1'b1;
                        end
                    end
                end
                pics_pkg::PH_INFLATE: begin
                    rep_valid      = 1'b1;
                    last_good_next = filt;
                    if (f_ge_target) begin
                        phase_next      = pics_pkg::PH_SETTLE;
                        wait_ticks_next = WW'(pics_pkg::SETTLE_TICKS);
                    end
                end
                pics_pkg::PH_SETTLE: begin
                    wait_ticks_next = done ? '0 : wait_ticks_reg - WW'(1);
                    if (done) begin
                        rep_valid          = 1'b1;
                        readouts_left_next = pics_pkg::READOUTS_AFTER_FIRST;
                        phase_next         = pics_pkg::PH_READOUT;
                        wait_ticks_next    = WW'(pics_pkg::GAP_TICKS);
                    end
                end
                pics_pkg::PH_READOUT: begin
                    wait_ticks_next = done ? '0 : wait_ticks_reg - WW'(1);
                    if (done) begin
                        rep_valid = 1'b1;
                        if (readouts_left_reg > RW'(1)) begin
                            readouts_left_next = readouts_left_reg - RW'(1);
                            wait_ticks_next    = WW'(pics_pkg::GAP_TICKS);
                        end else begin
                            readouts_left_next = '0;
                            phase_next         = pics_pkg::PH_PAUSE;
                            wait_ticks_next    = pause_wait;
                        end
                    end
                end
                pics_pkg::PH_PAUSE: begin
                    wait_ticks_next = done ? '0 : wait_ticks_reg - WW'(1);
                    if (done) begin
                        r_dec = (repeats_left_reg != '0) ? repeats_left_reg - CW'(1) : '0;
                        repeats_left_next = r_dec;
                        if (r_dec != '0) begin
                            do_br = 1'b1;
                        end else begin
                            do_scp = 1'b1;
                        end
                    end
                end
                pics_pkg::PH_CYCLE_PAUSE: begin
                    wait_ticks_next = done ? '0 : wait_ticks_reg - WW'(1);
                    if (done) begin
                        do_ce = 1'b1;
                    end
                end
                default: begin
                    fin = 1'b1;
                end
            endcase
        end

        // end of the repetitions of a cycle
        if (do_scp) begin
            if (cycle_wait != '0) begin
                phase_next      = pics_pkg::PH_CYCLE_PAUSE;
                wait_ticks_next = cycle_wait;
            end else if (repetition_count_reg == '0) begin
                fin = 1'b1;
            end else begin
                do_ce = 1'b1;
            end
        end

        // end of a cycle
        if (do_ce) begin
            c_dec = (cycles_left_reg != '0) ? cycles_left_reg - CW'(1) : '0;
            cycles_left_next = c_dec;
            if (c_dec == '0) begin
                fin = 1'b1;
            end else begin
                do_bc = 1'b1;
            end
        end

        // start of a cycle
        if (do_bc) begin
            repeats_left_next = repetition_count_reg;
            if (repetition_count_reg == '0) begin
                if (cycle_wait != '0) begin
                    phase_next      = pics_pkg::PH_CYCLE_PAUSE;
                    wait_ticks_next = cycle_wait;
                end else begin
                    fin = 1'b1;
                end
            end else begin
                do_br = 1'b1;
            end
        end

        // start of a repetition
        if (do_br) begin
            if (!f_ge_target) begin
                phase_next = pics_pkg::PH_INFLATE;
            end else begin
                phase_next      = pics_pkg::PH_SETTLE;
                wait_ticks_next = WW'(pics_pkg::SETTLE_TICKS);
            end
        end

        if (fin) begin
            phase_next         = pics_pkg::PH_IDLE;
            cycles_left_next   = '0;
            repeats_left_next  = '0;
            wait_ticks_next    = '0;
            readouts_left_next = '0;
            idle_ticks_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= pics_pkg::PH_IDLE;
            cycles_left_reg   <= '0;
            repeats_left_reg  <= '0;
            wait_ticks_reg    <= '0;
            readouts_left_reg <= '0;
            idle_ticks_reg    <= '0;
            last_good_reg     <= PW'(pics_pkg::LAST_GOOD_RESET);
        end else if (accept) begin
            phase_reg         <= phase_next;
            cycles_left_reg   <= cycles_left_next;
            repeats_left_reg  <= repeats_left_next;
            wait_ticks_reg    <= wait_ticks_next;
            readouts_left_reg <= readouts_left_next;
            idle_ticks_reg    <= idle_ticks_next;
            last_good_reg     <= last_good_next;
        end
    end

    // configuration registers: cleared at the end of a run, else written through the cfg port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_count_reg      <= '0;
            repetition_count_reg <= '0;
            pause_seconds_reg    <= '0;
            target_pressure_reg  <= '0;
        end else if (accept && fin) begin
            cycle_count_reg      <= '0;
            repetition_count_reg <= '0;
            pause_seconds_reg    <= '0;
            target_pressure_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                pics_pkg::CFG_CYCLE_COUNT:      cycle_count_reg      <= cfg_wr_data[CW-1:0];
                pics_pkg::CFG_REPETITION_COUNT: repetition_count_reg <= cfg_wr_data[CW-1:0];
                pics_pkg::CFG_PAUSE_SECONDS:    pause_seconds_reg    <= cfg_wr_data[CW-1:0];
                pics_pkg::CFG_TARGET_PRESSURE:  target_pressure_reg  <= cfg_wr_data[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            valve_reg        <= (phase_next == pics_pkg::PH_INFLATE);
            busy_reg         <= (phase_next != pics_pkg::PH_IDLE);
            report_valid_reg <= rep_valid;
            report_reg       <= rep_valid ? filt : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = report_valid_reg;
    assign m_axis_tdata  = {{(16 - PW - 2){1'b0}}, busy_reg, report_reg, valve_reg};

endmodule

@@ test/tb_pneumatic_inflate_cycle_sequencer.sv @@
`timescale 1ns / 1ps

module tb_pneumatic_inflate_cycle_sequencer;

    localparam int ITEMS_PER_MODE = 280;

    typedef struct packed {
        logic             valve;
        logic             rv;
        pics_pkg::press_t press;
        logic             busy;
    } seq_out_t;

    typedef enum {ROW_TICK, ROW_START, ROW_CFG} row_op_t;

    typedef struct {
        row_op_t     op;
        logic [15:0] sample;
        logic        link;
        logic        typed;
        seq_out_t    want;
        int          cyc;
        int          rep;
        int          pau;
        int          tgt;
    } row_t;

    logic                            aclk;
    logic                            aresetn       = 1'b0;
    logic                            cfg_wr_en     = 1'b0;
    logic [pics_pkg::CFG_IDX_W-1:0]  cfg_wr_index  = '0;
    logic [pics_pkg::CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [23:0]                     s_axis_tdata  = '0;  // pressure_sample, link_up
    logic                            s_axis_tuser  = 1'b0; // kind
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [15:0]                     m_axis_tdata;  // valve_open, report_pressure, busy_res
    logic                            m_axis_tuser;  // report_valid

    // model of the sequencer
    logic [pics_pkg::PHASE_W-1:0]  seq_phase;
    int                            cyc_left;
    int                            rep_left;
    int                            wait_cnt;
    int                            reads_left;
    int                            idle_cnt;
    pics_pkg::press_t              last_good;
    logic [pics_pkg::COUNT_W-1:0]  reg_cycles;
    logic [pics_pkg::COUNT_W-1:0]  reg_reps;
    logic [pics_pkg::COUNT_W-1:0]  reg_pause;
    logic [pics_pkg::TARGET_W-1:0] reg_target;

    seq_out_t pending_outputs[$];
    row_t     directed_rows[$];

    int snd_idle_pct   = 0;
    int rcv_idle_pct   = 0;
    int item_count     = 0;
    int runs_started   = 0;
    int result_count   = 0;
    int report_count   = 0;
    int valve_count    = 0;
    int mismatch_count = 0;

    pneumatic_inflate_cycle_sequencer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("%0t: run stalled, %0d results still outstanding", $time,
                 pending_outputs.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void end_run();
        seq_phase  = pics_pkg::PH_IDLE;
        cyc_left   = 0;
        rep_left   = 0;
        wait_cnt   = 0;
        reads_left = 0;
        idle_cnt   = 0;
        reg_cycles = '0;
        reg_reps   = '0;
        reg_pause  = '0;
        reg_target = '0;
    endfunction

    function automatic bit wait_over();
        if (wait_cnt > 1) begin
            wait_cnt--;
            return 1'b0;
        end
        wait_cnt = 0;
        return 1'b1;
    endfunction

    function automatic bit open_cycle_pause();
        int w;
        w = int'(reg_pause) * 2 * pics_pkg::TICKS_PER_SECOND;
        if (w == 0) return 1'b0;
        seq_phase = pics_pkg::PH_CYCLE_PAUSE;
        wait_cnt  = w;
        return 1'b1;
    endfunction

    function automatic void begin_rep(int f);
        if (f < int'(reg_target)) begin
            seq_phase = pics_pkg::PH_INFLATE;
        end else begin
            seq_phase = pics_pkg::PH_SETTLE;
            wait_cnt  = pics_pkg::SETTLE_TICKS;
        end
    endfunction

    function automatic void begin_cycle(int f);
        rep_left = int'(reg_reps);
        if (rep_left == 0) begin
            if (!open_cycle_pause()) end_run();
        end else begin
            begin_rep(f);
        end
    endfunction

    function automatic void cycle_done(int f);
        if (cyc_left > 0) cyc_left--;
        if (cyc_left == 0) end_run();
        else begin_cycle(f);
    endfunction

    function automatic seq_out_t advance_sequencer(logic is_start, logic [15:0] raw,
                                                   logic link);
        logic signed [15:0] sraw;
        int                 f;
        logic               rv;
        int                 rvalue;
        seq_out_t           res;
        sraw   = raw;
        rv     = 1'b0;
        rvalue = 0;
        if (is_start) begin
            if (seq_phase == pics_pkg::PH_IDLE && reg_target != '0)
                seq_phase = pics_pkg::PH_ARMED;
        end else begin
            if (sraw > pics_pkg::GLITCH_LIMIT || sraw < -pics_pkg::GLITCH_LIMIT)
                f = int'(last_good);
            else
                f = int'(sraw);
            case (seq_phase)
                pics_pkg::PH_IDLE: begin
                    if (!link) begin
                        idle_cnt = 0;
                    end else if (idle_cnt == 0) begin
                        rv        = 1'b1;
                        rvalue    = f;
                        last_good = pics_pkg::press_t'(f);
                        idle_cnt  = pics_pkg::TICKS_PER_SECOND - 1;
                    end else begin
                        idle_cnt--;
                    end
                end
                pics_pkg::PH_ARMED: begin
                    if (link) begin
                        cyc_left = int'(reg_cycles);
                        if (cyc_left == 0) end_run();
                        else begin_cycle(f);
                    end
                end
                pics_pkg::PH_INFLATE: begin
                    rv        = 1'b1;
                    rvalue    = f;
                    last_good = pics_pkg::press_t'(f);
                    if (f >= int'(reg_target)) begin
                        seq_phase = pics_pkg::PH_SETTLE;
                        wait_cnt  = pics_pkg::SETTLE_TICKS;
                    end
                end
                pics_pkg::PH_SETTLE: begin
                    if (wait_over()) begin
                        rv         = 1'b1;
                        rvalue     = f;
                        reads_left = int'(pics_pkg::READOUTS_AFTER_FIRST);
                        seq_phase  = pics_pkg::PH_READOUT;
                        wait_cnt   = pics_pkg::GAP_TICKS;
                    end
                end
                pics_pkg::PH_READOUT: begin
                    if (wait_over()) begin
                        rv     = 1'b1;
                        rvalue = f;
                        if (reads_left > 1) begin
                            reads_left--;
                            wait_cnt = pics_pkg::GAP_TICKS;
                        end else begin
                            reads_left = 0;
                            seq_phase  = pics_pkg::PH_PAUSE;
                            wait_cnt   = pics_pkg::GAP_TICKS
                                       + int'(reg_pause) * pics_pkg::TICKS_PER_SECOND;
                        end
                    end
                end
                pics_pkg::PH_PAUSE: begin
                    if (wait_over()) begin
                        if (rep_left > 0) rep_left--;
                        if (rep_left > 0) begin
                            begin_rep(f);
                        end else if (!open_cycle_pause()) begin
                            if (reg_reps == '0) end_run();
                            else cycle_done(f);
                        end
                    end
                end
                pics_pkg::PH_CYCLE_PAUSE: begin
                    if (wait_over()) cycle_done(f);
                end
                default: begin
                    end_run();
                end
            endcase
        end
        res.valve = (seq_phase == pics_pkg::PH_INFLATE);
        res.rv    = rv;
        res.press = pics_pkg::press_t'(rvalue);
        res.busy  = (seq_phase != pics_pkg::PH_IDLE);
        return res;
    endfunction

    function automatic seq_out_t seq_out(bit valve, bit rv, int press, bit busy);
        seq_out_t r;
        r.valve = valve;
        r.rv    = rv;
        r.press = pics_pkg::press_t'(press);
        r.busy  = busy;
        return r;
    endfunction

    function automatic row_t tick_row(int s, bit l);
        row_t r;
        r.op     = ROW_TICK;
        r.sample = 16'(s);
        r.link   = l;
        r.typed  = 1'b0;
        r.want   = '0;
        r.cyc    = 0;
        r.rep    = 0;
        r.pau    = 0;
        r.tgt    = 0;
        return r;
    endfunction

    function automatic row_t start_row();
        row_t r;
        r    = tick_row(0, 1'b0);
        r.op = ROW_START;
        return r;
    endfunction

    function automatic row_t cfg_row(int c, int rp, int pa, int t);
        row_t r;
        r     = tick_row(0, 1'b0);
        r.op  = ROW_CFG;
        r.cyc = c;
        r.rep = rp;
        r.pau = pa;
        r.tgt = t;
        return r;
    endfunction

    function automatic row_t checked(row_t r, seq_out_t w);
        row_t c;
        c       = r;
        c.typed = 1'b1;
        c.want  = w;
        return c;
    endfunction

    // mostly samples around the target, plus glitches, edges and raw noise
    function automatic logic [15:0] rand_sample();
        int v;
        case ($urandom_range(0, 9))
            0: v = int'($urandom_range(0, 65535));
            1: begin
                case ($urandom_range(0, 5))
                    0: v = pics_pkg::GLITCH_LIMIT;
                    1: v = -pics_pkg::GLITCH_LIMIT;
                    2: v = pics_pkg::GLITCH_LIMIT + 1;
                    3: v = -pics_pkg::GLITCH_LIMIT - 1;
                    4: v = 32767;
                    default: v = -32768;
                endcase
            end
            2: begin
                v = int'($urandom_range(pics_pkg::GLITCH_LIMIT + 1, 32767));
                if ($urandom_range(0, 1) == 0) v = -v;
            end
            default: begin
                v = int'(reg_target) + int'($urandom_range(0, 600)) - 350;
                if (v > pics_pkg::GLITCH_LIMIT) v = pics_pkg::GLITCH_LIMIT;
                if (v < -pics_pkg::GLITCH_LIMIT) v = -pics_pkg::GLITCH_LIMIT;
            end
        endcase
        return 16'(v);
    endfunction

    task automatic send_item(input logic kind, input logic [15:0] sample, input logic link,
                             input logic typed, input seq_out_t want);
        seq_out_t predicted;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, link, sample};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = advance_sequencer(kind, sample, link);
        pending_outputs.push_back(typed ? want : predicted);
        item_count++;
    endtask

    task automatic settle_outputs();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_config(input int c, input int rp, input int pa, input int t);
        logic [pics_pkg::CFG_IDX_W-1:0] idx [4];
        int                             val [4];
        idx[0] = pics_pkg::CFG_CYCLE_COUNT;
        idx[1] = pics_pkg::CFG_REPETITION_COUNT;
        idx[2] = pics_pkg::CFG_PAUSE_SECONDS;
        idx[3] = pics_pkg::CFG_TARGET_PRESSURE;
        val[0] = c;
        val[1] = rp;
        val[2] = pa;
        val[3] = t;
        reg_cycles = pics_pkg::COUNT_W'(c);
        reg_reps   = pics_pkg::COUNT_W'(rp);
        reg_pause  = pics_pkg::COUNT_W'(pa);
        reg_target = pics_pkg::TARGET_W'(t);
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= idx[i];
            cfg_wr_data  <= pics_pkg::CFG_DATA_W'(val[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        seq_out_t got;
        seq_out_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[0], m_axis_tuser, m_axis_tdata[13:1], m_axis_tdata[14]};
            result_count++;
            if (got.rv) report_count++;
            if (got.valve) valve_count++;
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected result, got %h", $time, got);
                mismatch_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (got.valve != want.valve) begin
                    $display("%0t: valve_open expected %0d, got %0d", $time,
                             want.valve, got.valve);
                    mismatch_count++;
                end
                if (got.rv != want.rv) begin
                    $display("%0t: report_valid expected %0d, got %0d", $time,
                             want.rv, got.rv);
                    mismatch_count++;
                end
                if (got.press != want.press) begin
                    $display("%0t: report_pressure expected %0d, got %0d", $time,
                             want.press, got.press);
                    mismatch_count++;
                end
                if (got.busy != want.busy) begin
                    $display("%0t: busy_res expected %0d, got %0d", $time,
                             want.busy, got.busy);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int c;
        int rp;
        int pa;
        int t;
        int n;
        int mode_start;

        end_run();
        last_good = pics_pkg::press_t'(pics_pkg::LAST_GOOD_RESET);

        directed_rows = '{
            // idle reporting, glitch filter and the magnitude edges
            checked(tick_row(2500, 1'b1), seq_out(0, 1, 2500, 0)),
            checked(tick_row(-2500, 1'b1), seq_out(0, 0, 0, 0)),
            checked(tick_row(0, 1'b0), seq_out(0, 0, 0, 0)),
            checked(tick_row(32767, 1'b1), seq_out(0, 1, 2500, 0)),
            checked(tick_row(0, 1'b0), seq_out(0, 0, 0, 0)),
            checked(tick_row(-32768, 1'b1), seq_out(0, 1, 2500, 0)),
            checked(tick_row(0, 1'b0), seq_out(0, 0, 0, 0)),
            checked(tick_row(-2500, 1'b1), seq_out(0, 1, -2500, 0)),
            // start with zero target is ignored
            checked(start_row(), seq_out(0, 0, 0, 0)),
            // empty run
            cfg_row(0, 0, 0, 100),
            checked(start_row(), seq_out(0, 0, 0, 1)),
            checked(tick_row(1234, 1'b1), seq_out(0, 0, 0, 0)),
            // one repetition that starts above target, link dropped mid run
            cfg_row(1, 1, 0, 100),
            checked(start_row(), seq_out(0, 0, 0, 1)),
            checked(tick_row(0, 1'b0), seq_out(0, 0, 0, 1)),
            checked(tick_row(300, 1'b1), seq_out(0, 0, 0, 1)),
            tick_row(0, 1'b0),
            tick_row(0, 1'b0),
            tick_row(0, 1'b0),
            tick_row(0, 1'b0),
            tick_row(5000, 1'b0),
            tick_row(700, 1'b1),
            tick_row(800, 1'b1),
            tick_row(900, 1'b1),
            tick_row(1000, 1'b1),
            tick_row(1100, 1'b1),
            tick_row(1200, 1'b1),
            // unreachable target, then lowered while inflating
            cfg_row(1, 1, 0, 9900),
            checked(start_row(), seq_out(0, 0, 0, 1)),
            checked(tick_row(0, 1'b1), seq_out(1, 0, 0, 1)),
            checked(tick_row(2500, 1'b1), seq_out(1, 1, 2500, 1)),
            cfg_row(1, 1, 0, 5000),
            checked(tick_row(-32768, 1'b1), seq_out(1, 1, 2500, 1)),
            cfg_row(1, 1, 0, 100)
        };

        snd_idle_pct = 35;
        rcv_idle_pct = 55;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            case (directed_rows[i].op)
                ROW_CFG: begin
                    settle_outputs();
                    write_config(directed_rows[i].cyc, directed_rows[i].rep,
                                 directed_rows[i].pau, directed_rows[i].tgt);
                end
                ROW_START: begin
                    send_item(1'b1, 16'($urandom), 1'($urandom), directed_rows[i].typed,
                              directed_rows[i].want);
                end
                default: begin
                    send_item(1'b0, directed_rows[i].sample, directed_rows[i].link,
                              directed_rows[i].typed, directed_rows[i].want);
                end
            endcase
        end

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    snd_idle_pct = 35;
                    rcv_idle_pct = 55;
                end
                1: begin
                    snd_idle_pct = 55;
                    rcv_idle_pct = 35;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            mode_start = item_count;
            while (item_count - mode_start < ITEMS_PER_MODE) begin
                c  = $urandom_range(1, 3);
                rp = $urandom_range(0, 3);
                pa = $urandom_range(0, 1);
                t  = 100 * $urandom_range(1, 25);
                case ($urandom_range(0, 29))
                    0: begin
                        c  = 99;
                        rp = 0;
                        pa = 0;
                    end
                    1: begin
                        c  = $urandom_range(4, 8);
                        rp = 1;
                        pa = 0;
                    end
                    2: begin
                        c  = 1;
                        rp = $urandom_range(4, 8);
                        pa = 0;
                    end
                    3: begin
                        c  = 1;
                        rp = 1;
                        pa = $urandom_range(2, 4);
                    end
                    4: t = 2500;
                    5: c = 0;
                    6: begin
                        c  = $urandom_range(0, 99);
                        rp = 0;
                        pa = 0;
                    end
                    7: begin
                        c  = 1;
                        rp = $urandom_range(0, 8);
                        pa = 0;
                    end
                    8: begin
                        c  = 1;
                        rp = 0;
                        pa = $urandom_range(0, 4);
                    end
                    9: t = 0;
                    default: ;
                endcase
                settle_outputs();
                write_config(c, rp, pa, t);
                n = $urandom_range(0, 12);
                repeat (n) send_item(1'b0, rand_sample(), ($urandom_range(0, 3) != 0),
                                     1'b0, '0);
                send_item(1'b1, 16'($urandom), 1'($urandom), 1'b0, '0);
                if (seq_phase == pics_pkg::PH_ARMED) runs_started++;
                if ($urandom_range(0, 4) == 0)
                    send_item(1'b1, 16'($urandom), 1'($urandom), 1'b0, '0);
                while (seq_phase != pics_pkg::PH_IDLE) begin
                    if ($urandom_range(0, 49) == 0)
                        send_item(1'b1, 16'($urandom), 1'($urandom), 1'b0, '0);
                    else
                        send_item(1'b0, rand_sample(), ($urandom_range(0, 9) != 0),
                                  1'b0, '0);
                end
                n = $urandom_range(0, 12);
                repeat (n) send_item(1'b0, rand_sample(), ($urandom_range(0, 3) != 0),
                                     1'b0, '0);
            end
        end

        settle_outputs();
        $display("%0d items sent, %0d runs started, %0d results checked",
                 item_count, runs_started, result_count);
        $display("%0d pressure reports, %0d results with the valve open",
                 report_count, valve_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
